// ===== hdl/mtpc_pkg.sv =====
`default_nettype none
package mtpc_pkg;

  localparam int KEY_W       = 40;
  localparam int QUEUE_DEPTH = 4;
  localparam int ETH_LEN     = 14;
  localparam int IPV6_HDR    = 40;
  localparam int L4_BYTES    = 2 + 2;
  localparam logic [15:0] KIND_IPV4 = 16'h0800;
  localparam logic [15:0] KIND_IPV6 = 16'h86DD;
  localparam logic [6:0]  POS_MAX   = 7'd127;

  typedef enum logic [1:0] {
    REQ_PACKET = 2'd0,
    REQ_MASK   = 2'd1,
    REQ_RULE   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    VERDICT_PASS     = 2'd0,
    VERDICT_DROP     = 2'd1,
    VERDICT_REDIRECT = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    OP_MASK  = 2'd0,
    OP_RULE  = 2'd1,
    OP_FRAME = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_CMP  = 2'd2,
    ST_EMIT = 2'd3
  } state_t;

  typedef struct packed {
    op_t              op;
    verdict_t         pre;
    logic             lookup;
    logic [3:0]       index;
    logic [KEY_W-1:0] key;
    logic             valid;
    logic [5:0]       queue;
  } entry_t;

  typedef struct packed {
    logic pop;
    logic ram_we;
    logic load_out;
  } back_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/mtpc_ram.sv =====
`default_nettype none
module mtpc_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/mtpc_queue.sv =====
`default_nettype none
module mtpc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire mtpc_pkg::entry_t push_entry,
  input  wire logic            pop,
  output mtpc_pkg::entry_t     head,
  output logic                 empty,
  output logic                 full
);
  import mtpc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  entry_t        slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        slots[wptr] <= push_entry;
        wptr        <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/mtpc_front.sv =====
`default_nettype none
module mtpc_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  req_type,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        last_byte,
  input  wire logic [5:0]                  rx_queue,
  input  wire logic [3:0]                  entry_index,
  input  wire logic [mtpc_pkg::KEY_W-1:0]  entry_key,
  input  wire logic                        entry_valid,
  input  wire logic                        q_full,
  output logic                             push,
  output mtpc_pkg::entry_t                 push_entry
);
  import mtpc_pkg::*;

  logic [6:0]       byte_position;
  logic [15:0]      ether_kind;
  logic [3:0]       header_length;
  logic [KEY_W-1:0] packet_key;

  logic [15:0]      kind_now;
  logic [3:0]       hl_now;
  logic [KEY_W-1:0] key_now;
  logic [6:0]       l4_start;
  logic [6:0]       l4_diff;
  logic [7:0]       len;
  logic             accept;
  logic             is_packet;
  verdict_t         pre;
  logic             lookup;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign is_packet = (req_type == REQ_PACKET);
  assign len       = {1'b0, byte_position} + 8'd1;

  always_comb begin
    kind_now = ether_kind;
    if (byte_position == 7'd12) begin
      kind_now = {data_byte, ether_kind[7:0]};
    end else if (byte_position == 7'd13) begin
      kind_now = {ether_kind[15:8], data_byte};
    end
    hl_now = (byte_position == 7'(ETH_LEN)) ? data_byte[3:0] : header_length;

    l4_start = '0;
    if (kind_now == KIND_IPV4) begin
      l4_start = (hl_now >= 4'd5) ? 7'(ETH_LEN) + {1'b0, hl_now, 2'b00} : 7'd0;
    end else if (kind_now == KIND_IPV6) begin
      l4_start = 7'(ETH_LEN + IPV6_HDR);
    end
    l4_diff = byte_position - l4_start;

    key_now = packet_key;
    if ((kind_now == KIND_IPV4 && byte_position == 7'(ETH_LEN + 9)) ||
        (kind_now == KIND_IPV6 && byte_position == 7'(ETH_LEN + 6))) begin
      key_now[39:32] = data_byte;
    end
    if (l4_start != '0 && byte_position >= l4_start && l4_diff < 7'(L4_BYTES)) begin
      case (l4_diff[1:0])
        2'd0:    key_now[31:24] = data_byte;
        2'd1:    key_now[23:16] = data_byte;
        2'd2:    key_now[15:8]  = data_byte;
        default: key_now[7:0]   = data_byte;
      endcase
    end

    pre    = VERDICT_PASS;
    lookup = 1'b0;
    if (len < 8'(ETH_LEN)) begin
      pre = VERDICT_DROP;
    end else if (kind_now == KIND_IPV4) begin
      if (hl_now < 4'd5 ||
          len < 8'(ETH_LEN + L4_BYTES) + {2'b00, hl_now, 2'b00}) begin
        pre = VERDICT_DROP;
      end else begin
        lookup = 1'b1;
      end
    end else if (kind_now == KIND_IPV6) begin
      if (len < 8'(ETH_LEN + IPV6_HDR + L4_BYTES)) begin
        pre = VERDICT_DROP;
      end else begin
        lookup = 1'b1;
      end
    end
  end

  always_comb begin
    push_entry.pre    = pre;
    push_entry.lookup = lookup;
    push_entry.index  = entry_index;
    push_entry.valid  = entry_valid;
    push_entry.queue  = rx_queue;
    push_entry.key    = entry_key;
    push_entry.op     = OP_FRAME;
    push              = 1'b0;
    case (req_type)
      REQ_PACKET: begin
        push_entry.key = key_now;
        push           = accept && last_byte;
      end
      REQ_MASK: begin
        push_entry.op = OP_MASK;
        push          = accept;
      end
      REQ_RULE: begin
        push_entry.op = OP_RULE;
        push          = accept;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      ether_kind    <= '0;
      header_length <= '0;
      packet_key    <= '0;
    end else if (accept && is_packet) begin
      if (last_byte) begin
        byte_position <= '0;
        ether_kind    <= '0;
        header_length <= '0;
        packet_key    <= '0;
      end else begin
        if (byte_position != POS_MAX) begin
          byte_position <= byte_position + 1'b1;
        end
        ether_kind    <= kind_now;
        header_length <= hl_now;
        packet_key    <= key_now;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/mtpc_back.sv =====
`default_nettype none
module mtpc_back #(
  parameter int MASK_ENTRIES = 16,
  parameter int RULE_ENTRIES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mtpc_pkg::entry_t head,
  input  wire logic             q_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mtpc_pkg::verdict_t    verdict,
  output logic [5:0]            out_queue,
  output logic [31:0]           invalid_count,
  output logic [31:0]           matched_count
);
  import mtpc_pkg::*;

  localparam int MW = MASK_ENTRIES > 1 ? $clog2(MASK_ENTRIES) : 1;
  localparam int RW = RULE_ENTRIES > 1 ? $clog2(RULE_ENTRIES) : 1;

  state_t           state;
  state_t           state_next;
  back_ctl_t        ctl;
  entry_t           cur;
  verdict_t         result;
  logic [MW-1:0]    m;
  logic             hit;
  logic [KEY_W-1:0] mask_rdata;
  logic [KEY_W-1:0] masked;
  logic [MASK_ENTRIES-1:0] mask_set;
  logic [KEY_W-1:0] rule_key [RULE_ENTRIES];
  logic [RULE_ENTRIES-1:0] rule_on;
  logic [7:0]       index_ext;
  logic             mask_in_range;
  logic             rule_in_range;
  logic             m_last;
  logic             slot_free;

  assign index_ext     = {4'b0000, head.index};
  assign mask_in_range = (32'(head.index) < MASK_ENTRIES);
  assign rule_in_range = (32'(head.index) < RULE_ENTRIES);
  assign m_last        = (m == MW'(MASK_ENTRIES - 1));
  assign slot_free     = !out_valid || out_ready;
  assign pop           = ctl.pop;
  assign masked        = cur.key & (mask_set[m] ? mask_rdata : '0);

  mtpc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MASK_ENTRIES)
  ) u_mask_ram (
    .clk   (clk),
    .we    (ctl.ram_we),
    .waddr (index_ext[MW-1:0]),
    .wdata (head.key),
    .raddr (m),
    .rdata (mask_rdata)
  );

  always_comb begin
    hit = 1'b0;
    for (int r = 0; r < RULE_ENTRIES; r++) begin
      if (rule_on[r] && rule_key[r] == masked) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty && head.op == OP_FRAME) begin
          state_next = head.lookup ? ST_READ : ST_EMIT;
        end
      end
      ST_READ: state_next = ST_CMP;
      ST_CMP:  state_next = (hit || m_last) ? ST_EMIT : ST_READ;
      ST_EMIT: state_next = slot_free ? ST_IDLE : ST_EMIT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE: begin
        ctl.pop    = !q_empty;
        ctl.ram_we = !q_empty && head.op == OP_MASK && mask_in_range;
      end
      ST_EMIT: ctl.load_out = slot_free;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mask_set      <= '0;
      rule_on       <= '0;
      out_valid     <= 1'b0;
      invalid_count <= '0;
      matched_count <= '0;
    end else begin
      state <= state_next;
      if (ctl.ram_we) begin
        mask_set[index_ext[MW-1:0]] <= 1'b1;
      end
      if (ctl.pop && head.op == OP_RULE && rule_in_range) begin
        rule_on[index_ext[RW-1:0]] <= head.valid;
      end
      if (ctl.load_out) begin
        out_valid <= 1'b1;
        if (result == VERDICT_DROP && invalid_count != '1) begin
          invalid_count <= invalid_count + 1'b1;
        end
        if (result == VERDICT_REDIRECT && matched_count != '1) begin
          matched_count <= matched_count + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop && head.op == OP_RULE && rule_in_range) begin
      rule_key[index_ext[RW-1:0]] <= head.key;
    end
    if (state == ST_IDLE && !q_empty && head.op == OP_FRAME) begin
      cur    <= head;
      result <= head.pre;
      m      <= '0;
    end
    if (state == ST_CMP) begin
      if (hit) begin
        result <= VERDICT_REDIRECT;
      end else if (!m_last) begin
        m <= m + 1'b1;
      end
    end
    if (ctl.load_out) begin
      verdict   <= result;
      out_queue <= (result == VERDICT_REDIRECT) ? cur.queue : 6'd0;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/masked_tuple_packet_classifier.sv =====
`default_nettype none
// Frame bytes and table writes enter one per cycle while the four-entry
// queue has room. Each frame's last byte queues one classification; the
// search engine then steps through each mask slot with a RAM read, then a
// compare against all rules at once, stopping at the first hit or after
// the last mask; frames without lookup (drop or pass) skip the search.
// Table writes are applied in order with frames.
module masked_tuple_packet_classifier #(
  parameter int MASK_ENTRIES = 16,
  parameter int RULE_ENTRIES = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 req_type,
  input  wire logic [7:0]                 data_byte,
  input  wire logic                       last_byte,
  input  wire logic [5:0]                 rx_queue,
  input  wire logic [3:0]                 entry_index,
  input  wire logic [mtpc_pkg::KEY_W-1:0] entry_key,
  input  wire logic                       entry_valid,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output mtpc_pkg::verdict_t              verdict,
  output logic [5:0]                      out_queue,
  output logic [31:0]                     invalid_count,
  output logic [31:0]                     matched_count
);
  import mtpc_pkg::*;

  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   q_empty;
  logic   q_full;

  mtpc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .rx_queue    (rx_queue),
    .entry_index (entry_index),
    .entry_key   (entry_key),
    .entry_valid (entry_valid),
    .q_full      (q_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  mtpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  mtpc_back #(
    .MASK_ENTRIES (MASK_ENTRIES),
    .RULE_ENTRIES (RULE_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .verdict       (verdict),
    .out_queue     (out_queue),
    .invalid_count (invalid_count),
    .matched_count (matched_count)
  );

  a_queue_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != VERDICT_REDIRECT |-> out_queue == 6'd0)
    else $error("queue id on non-redirect item");

  a_match_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == VERDICT_REDIRECT |-> matched_count != 32'd0)
    else $error("redirect without match count");

  a_drop_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == VERDICT_DROP |-> invalid_count != 32'd0)
    else $error("drop without drop count");

endmodule
`default_nettype wire
